@@ hw/rtl/pcwh_pkg.sv @@
package pcwh_pkg;

  // Default sizing of the datapath.
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int COUNT_BITS_DEF  = 24;

  // Fixed field widths on the ports.
  localparam int SMP_W  = 12;
  localparam int TIME_W = 32;
  localparam int LEN_W  = 24;
  localparam int STAT_W = 2;
  localparam int PEAK_W = 12;
  localparam int MEAN_W = 12;
  localparam int THR_W  = 12;
  localparam int MIN_W  = 24;

  localparam int CFG_DATA_W = 24;
  localparam int CFG_ADDR_W = 2;

  localparam int IN_FIELDS_W  = SMP_W + TIME_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STAT_W + TIME_W + LEN_W + PEAK_W + MEAN_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_UPPER = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LOWER = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FLOOR = 2'd3;

  // Pulse status codes.
  localparam logic [STAT_W-1:0] STATUS_OUTSIDE = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_INSIDE  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_READY   = 2'd2;

  typedef struct packed {
    logic [THR_W-1:0]  upper;
    logic [THR_W-1:0]  lower;
    logic [MIN_W-1:0]  min_dur;
    logic [PEAK_W-1:0] floor_lvl;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic report;
  } stat_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic [PEAK_W-1:0] peak;
    logic [LEN_W-1:0]  len;
    logic [TIME_W-1:0] stamp;
    logic [STAT_W-1:0] status;
  } res_t;

endpackage

@@ hw/rtl/pcwh_ctrl.sv @@
module pcwh_ctrl #(
  parameter int SAMPLE_BITS = pcwh_pkg::SAMPLE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            out_free,
  input  pcwh_pkg::stat_t st,
  output pcwh_pkg::cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam int STEP_W = $clog2(SAMPLE_BITS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SAMPLE_BITS - 1);

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [STEP_W-1:0] step;

  assign in_ready     = (state == ST_IDLE);
  assign cmd.load_in  = (state == ST_IDLE) && in_valid;
  assign cmd.eval     = (state == ST_EVAL);
  assign cmd.div_step = (state == ST_DIV);
  assign cmd.emit     = (state == ST_EMIT) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_EVAL;
      ST_EVAL: state_next = st.report ? ST_DIV : ST_EMIT;
      ST_DIV:  if (step == STEP_LAST) state_next = ST_EMIT;
      ST_EMIT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) begin
        step <= (step == STEP_LAST) ? '0 : step + 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("result emitted while output register busy");
  a_report_div: assert property (@(posedge clk) disable iff (rst)
    cmd.eval && st.report |=> cmd.div_step && step == '0)
    else $error("reported pulse did not start division");
  a_div_end: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step && step == STEP_LAST |=> state == ST_EMIT)
    else $error("division did not end in emit");
  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    state != ST_DIV |-> step == '0)
    else $error("divider step count left over");
`endif

endmodule

@@ hw/rtl/pcwh_dp.sv @@
module pcwh_dp #(
  parameter int SAMPLE_BITS = pcwh_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = pcwh_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pcwh_pkg::cfg_t                    cfg,
  input  pcwh_pkg::cmd_t                    cmd,
  input  logic [pcwh_pkg::IN_TDATA_W-1:0]   in_data,
  output pcwh_pkg::stat_t                   st,
  output pcwh_pkg::res_t                    res
);

  localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;
  localparam int CMP_W = (COUNT_BITS > pcwh_pkg::MIN_W) ? COUNT_BITS : pcwh_pkg::MIN_W;
  localparam int PK_W  = pcwh_pkg::PEAK_W;

  // Latched input word.
  logic [SAMPLE_BITS-1:0]        smp;
  logic [pcwh_pkg::TIME_W-1:0]   tstamp;

  // Pulse state.
  logic                          in_pulse;
  logic [pcwh_pkg::TIME_W-1:0]   pulse_start;
  logic [COUNT_BITS-1:0]         sample_count;
  logic [SUM_W-1:0]              sample_sum;
  logic [PK_W-1:0]               running_peak;

  // Divider: remainder, dividend bits shifting out / quotient bits shifting in.
  logic [COUNT_BITS-1:0]         rem;
  logic [SAMPLE_BITS-1:0]        quo;
  logic [SAMPLE_BITS-1:0]        quo_next;
  logic [COUNT_BITS-1:0]         dvs;

  logic [PK_W-1:0]               smp_pk;
  logic                          open_hit;
  logic                          close_hit;
  logic [COUNT_BITS-1:0]         count_rec;
  logic [SUM_W-1:0]              sum_rec;
  logic [PK_W-1:0]               peak_rec;
  logic [PK_W-1:0]               peak_open;
  logic [COUNT_BITS-1:0]         dur;
  logic                          long_enough;
  logic [COUNT_BITS:0]           trial;
  logic [COUNT_BITS:0]           diff;

  assign smp_pk    = (SAMPLE_BITS > PK_W) ? PK_W'(smp) : PK_W'(smp);
  assign open_hit  = smp_pk >= cfg.upper;
  assign close_hit = smp_pk < cfg.lower;

  // Recording a sample inside an open pulse; count and sum stop once full.
  always_comb begin
    if (sample_count != '1) begin
      count_rec = sample_count + 1'b1;
      sum_rec   = sample_sum + SUM_W'(smp);
    end else begin
      count_rec = sample_count;
      sum_rec   = sample_sum;
    end
    peak_rec  = (smp_pk > running_peak) ? smp_pk : running_peak;
    peak_open = (smp_pk > cfg.floor_lvl) ? smp_pk : cfg.floor_lvl;
  end

  assign dur         = count_rec - 1'b1;
  assign long_enough = CMP_W'(dur) > CMP_W'(cfg.min_dur);
  assign st.report   = in_pulse && close_hit && long_enough;

  assign trial    = {rem, quo[SAMPLE_BITS-1]};
  assign diff     = trial - {1'b0, dvs};
  assign quo_next = {quo[SAMPLE_BITS-2:0], !diff[COUNT_BITS]};

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      smp    <= SAMPLE_BITS'(in_data[pcwh_pkg::SMP_W-1:0]);
      tstamp <= in_data[pcwh_pkg::SMP_W +: pcwh_pkg::TIME_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_pulse     <= 1'b0;
      pulse_start  <= '0;
      sample_count <= '0;
      sample_sum   <= '0;
      running_peak <= '0;
    end else if (cmd.eval) begin
      if (!in_pulse) begin
        if (open_hit) begin
          in_pulse     <= 1'b1;
          pulse_start  <= tstamp;
          sample_count <= COUNT_BITS'(1);
          sample_sum   <= SUM_W'(smp);
          running_peak <= peak_open;
        end
      end else if (close_hit) begin
        in_pulse     <= 1'b0;
        pulse_start  <= '0;
        sample_count <= '0;
        sample_sum   <= '0;
        running_peak <= cfg.floor_lvl;
      end else begin
        sample_count <= count_rec;
        sample_sum   <= sum_rec;
        running_peak <= peak_rec;
      end
    end
  end

  // Result fields and the divider; the mean follows the quotient as its bits come in.
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      if (st.report) begin
        res.status <= pcwh_pkg::STATUS_READY;
        res.stamp  <= pulse_start;
        res.len    <= pcwh_pkg::LEN_W'(dur);
        res.peak   <= peak_rec;
        res.mean   <= '0;
        rem        <= sum_rec[SUM_W-1:SAMPLE_BITS];
        quo        <= sum_rec[SAMPLE_BITS-1:0];
        dvs        <= count_rec;
      end else begin
        res.status <= (in_pulse ? !close_hit : open_hit) ?
                      pcwh_pkg::STATUS_INSIDE : pcwh_pkg::STATUS_OUTSIDE;
        res.stamp  <= '0;
        res.len    <= '0;
        res.peak   <= '0;
        res.mean   <= '0;
        rem        <= '0;
        quo        <= '0;
        dvs        <= '0;
      end
    end else if (cmd.div_step) begin
      quo      <= quo_next;
      res.mean <= pcwh_pkg::MEAN_W'(quo_next);
      if (!diff[COUNT_BITS]) begin
        rem <= diff[COUNT_BITS-1:0];
      end else begin
        rem <= trial[COUNT_BITS-1:0];
      end
    end
  end

`ifndef ASSERT_OFF
  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.eval && in_pulse && close_hit |=> !in_pulse && sample_count == '0)
    else $error("closed pulse left state behind");
  a_count_live: assert property (@(posedge clk) disable iff (rst)
    in_pulse |-> sample_count != '0)
    else $error("open pulse with empty count");
`endif

endmodule

@@ hw/rtl/pulse_capture_with_hysteresis.sv @@
// Pulse capture with hysteresis. Each input word carries one converter sample
// and a timestamp, and every accepted word yields exactly one output word. While
// no pulse is open, a sample at or above the upper threshold opens one, stores
// the timestamp and starts counting, summing and tracking the peak (the peak
// starts from the peak floor register). Inside a pulse every sample is
// recorded, the closing one included, and a sample below the lower threshold
// closes it. The duration is the recorded count minus one; if it exceeds the
// minimum duration the output word reports the pulse as ready with its start
// time, duration, peak and truncated mean, otherwise the pulse is dropped and
// the word shows the status outside. The count saturates at its full value and
// the sum then stops growing, so the mean stays exact. A word that does not
// report a pulse is evaluated and then loaded into the output register; a
// reporting word passes between those steps through the mean divider, which
// produces one quotient bit per cycle. A busy output register stalls the load,
// and a new word is accepted only once the last one has been loaded there. The
// output register lets the next input word be accepted while a result still
// waits on the master side. Registers are to be written only while the block
// is idle; the block itself does not enforce this. There is no clearing pass.
module pulse_capture_with_hysteresis #(
  parameter int SAMPLE_BITS = pcwh_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = pcwh_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Slave side; tdata from bit 0: sample[11:0], time_now[31:0], zero pad.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [pcwh_pkg::IN_TDATA_W-1:0]     s_tdata,
  // Master side; tdata from bit 0: pulse_status[1:0], start_stamp[31:0],
  // pulse_length[23:0], peak_level[11:0], mean_level[11:0], zero pad.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [pcwh_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [pcwh_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [pcwh_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  pcwh_pkg::cfg_t  cfg;
  pcwh_pkg::cmd_t  cmd;
  pcwh_pkg::stat_t st;
  pcwh_pkg::res_t  res;
  logic            out_free;

  // Configuration registers; the index is exactly as wide as the register list.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.upper     <= '1;
      cfg.lower     <= '0;
      cfg.min_dur   <= '0;
      cfg.floor_lvl <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pcwh_pkg::REG_UPPER: cfg.upper     <= cfg_wdata[pcwh_pkg::THR_W-1:0];
        pcwh_pkg::REG_LOWER: cfg.lower     <= cfg_wdata[pcwh_pkg::THR_W-1:0];
        pcwh_pkg::REG_MIN:   cfg.min_dur   <= cfg_wdata[pcwh_pkg::MIN_W-1:0];
        pcwh_pkg::REG_FLOOR: cfg.floor_lvl <= cfg_wdata[pcwh_pkg::PEAK_W-1:0];
        default: ;
      endcase
    end
  end

  // The output register may be loaded when it is empty or being drained now.
  assign out_free = !m_tvalid || m_tready;

  pcwh_ctrl #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_free (out_free),
    .st       (st),
    .cmd      (cmd)
  );

  pcwh_dp #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cmd     (cmd),
    .in_data (s_tdata),
    .st      (st),
    .res     (res)
  );

  // Output register. The result struct is packed with the status in the low
  // bits, which matches the tdata layout listed on the port.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= pcwh_pkg::OUT_TDATA_W'(res);
    end
  end

endmodule
